### src/ilp_pkg.sv
package ilp_pkg;

  // Default width of the signed result range the magnitude is checked against.
  localparam int unsigned ILP_RESULT_WIDTH = 32;

  // Width of the value field on the result channel.
  localparam int unsigned VALUE_W = 32;

  // Parser phase codes.
  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_PREFIX = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_ERROR  = 3'd5;

  // Radix codes.
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_HEX = 2'd1;
  localparam logic [1:0] RADIX_BIN = 2'd2;

  // ASCII characters of interest.
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UD    = 8'h44;
  localparam logic [7:0] CH_LD    = 8'h64;

  // Digit decode result: value and whether the byte is a digit of the radix.
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t decode_digit(input logic [7:0] c, input logic [1:0] radix);
    digit_t     d;
    logic [7:0] tmp;
    d   = '{ok: 1'b0, val: 4'd0};
    tmp = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      tmp   = c - CH_0;
      d.val = tmp[3:0];
      d.ok  = 1'b1;
    end else if (radix == RADIX_HEX && c >= CH_LA && c <= CH_LF) begin
      tmp   = c - CH_LA + 8'd10;
      d.val = tmp[3:0];
      d.ok  = 1'b1;
    end else if (radix == RADIX_HEX && c >= CH_UA && c <= CH_UF) begin
      tmp   = c - CH_UA + 8'd10;
      d.val = tmp[3:0];
      d.ok  = 1'b1;
    end
    // Reject digits that are too large for the radix.
    case (radix)
      RADIX_BIN: if (d.val > 4'd1) d.ok = 1'b0;
      RADIX_HEX: ;
      default:   if (d.val > 4'd9) d.ok = 1'b0;
    endcase
    return d;
  endfunction

endpackage

### src/integer_literal_parser_top.sv
// Channel  | Direction | Beat contents
// in_      | slave     | tdata[7:0] character, tlast marks the final byte of a lexeme
// out_     | master    | tdata[31:0] signed value, tuser valid_res; one beat per lexeme
//
// One byte is taken per cycle; the parser state and the output register are updated by a
// single level of logic (digit decode, multiply by 2, 10 or 16 as shifts and adds, compare).
// The result for a lexeme appears in the cycle after its final byte is accepted.
// Reset (rst_n low, synchronous) returns the parser to the start of a lexeme and empties
// the output register.
// A result held back by a low out_tready stalls the input until that beat is taken.
module integer_literal_parser_top
  import ilp_pkg::*;
#(
  parameter int unsigned RESULT_WIDTH = ILP_RESULT_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] character
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [VALUE_W-1:0] out_tdata,  // [31:0] value
  output logic               out_tuser   // [0] valid_res
);

  localparam int unsigned PW    = RESULT_WIDTH + 5;
  localparam int unsigned EXT_W = 64;
  localparam logic [RESULT_WIDTH-1:0] LIMIT = RESULT_WIDTH'(1) << (RESULT_WIDTH - 1);

  logic [2:0]              phase_r, phase_nxt;
  logic [1:0]              radix_r, radix_nxt;
  logic                    minus_r, minus_nxt;
  logic [RESULT_WIDTH-1:0] mag_r, mag_nxt;
  logic                    big_r, big_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [VALUE_W-1:0] out_val_r, out_val_nxt;

  logic                    in_acc;
  digit_t                  dig;
  logic [PW-1:0]           mag_ext, scaled, acc_sum;
  logic                    ok;
  logic [RESULT_WIDTH-1:0] sval;
  logic [EXT_W-1:0]        sval_ext;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Digit decode and next magnitude for the radix in use.
  always_comb begin
    dig     = decode_digit(in_tdata, radix_r);
    mag_ext = PW'(mag_r);
    case (radix_r)
      RADIX_HEX: scaled = mag_ext << 4;
      RADIX_BIN: scaled = mag_ext << 1;
      default:   scaled = (mag_ext << 3) + (mag_ext << 1);
    endcase
    acc_sum = scaled + PW'(dig.val);
  end

  // Parser state update for one accepted byte.
  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    minus_nxt = minus_r;
    mag_nxt   = mag_r;
    big_nxt   = big_r;
    case (phase_r)
      PH_START, PH_SIGN, PH_PREFIX, PH_DIGITS: begin
        if (phase_r == PH_START && in_tdata == CH_MINUS) begin
          minus_nxt = 1'b1;
          phase_nxt = PH_SIGN;
        end else if ((phase_r == PH_START || phase_r == PH_SIGN) && in_tdata == CH_0) begin
          phase_nxt = PH_ZERO;
        end else if (!dig.ok) begin
          phase_nxt = PH_ERROR;
        end else begin
          phase_nxt = PH_DIGITS;
          if (!big_r) begin
            if (acc_sum > PW'(LIMIT)) begin
              big_nxt = 1'b1;
            end else begin
              mag_nxt = acc_sum[RESULT_WIDTH-1:0];
            end
          end
        end
      end
      PH_ZERO: begin
        if (in_tdata == CH_LX || in_tdata == CH_UX) begin
          radix_nxt = RADIX_HEX;
          phase_nxt = PH_PREFIX;
        end else if (in_tdata == CH_LB || in_tdata == CH_UB) begin
          radix_nxt = RADIX_BIN;
          phase_nxt = PH_PREFIX;
        end else if (in_tdata == CH_LD || in_tdata == CH_UD) begin
          radix_nxt = RADIX_DEC;
          phase_nxt = PH_PREFIX;
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      default: phase_nxt = PH_ERROR;
    endcase
  end

  // Verdict and signed value on the final byte.
  always_comb begin
    ok = 1'b0;
    if (phase_nxt == PH_ZERO) begin
      ok = 1'b1;
    end else if (phase_nxt == PH_DIGITS && !big_nxt) begin
      ok = minus_nxt ? (mag_nxt <= LIMIT) : (mag_nxt < LIMIT);
    end
    sval = '0;
    if (ok && phase_nxt != PH_ZERO) begin
      sval = minus_nxt ? (RESULT_WIDTH'(0) - mag_nxt) : mag_nxt;
    end
    sval_ext = {{(EXT_W - RESULT_WIDTH){sval[RESULT_WIDTH-1]}}, sval};
  end

  // Output register: loaded on a final byte, emptied when the beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_val_nxt   = out_val_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc && in_tlast) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = ok;
      out_val_nxt   = sval_ext[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      radix_r     <= RADIX_DEC;
      minus_r     <= 1'b0;
      mag_r       <= '0;
      big_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        if (in_tlast) begin
          phase_r <= PH_START;
          radix_r <= RADIX_DEC;
          minus_r <= 1'b0;
          mag_r   <= '0;
          big_r   <= 1'b0;
        end else begin
          phase_r <= phase_nxt;
          radix_r <= radix_nxt;
          minus_r <= minus_nxt;
          mag_r   <= mag_nxt;
          big_r   <= big_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r  <= out_ok_nxt;
    out_val_r <= out_val_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_ok_r;

  // A rejected lexeme always reports a zero value.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ok_r |-> out_val_r == '0)
    else $error("rejected lexeme carries a non-zero value");

  // The final byte of a lexeme puts the parser back at its start.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> phase_r == PH_START && mag_r == '0 && !big_r && !minus_r)
    else $error("parser state not cleared after final byte");

  // The magnitude never grows past the range limit.
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mag_r <= LIMIT)
    else $error("magnitude beyond limit");

  // The overflow flag is only set once digits have been taken.
  a_big_phase: assert property (@(posedge clk) disable iff (!rst_n)
    big_r |-> phase_r == PH_DIGITS || phase_r == PH_ERROR)
    else $error("overflow flag set outside digit phases");

  // A byte that does not close a lexeme produces no result.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_tlast && !out_valid_r |=> !out_valid_r)
    else $error("result produced without a final byte");

endmodule
